// File: rtl/core/sha_nonce_pkg.sv
// Package for the double SHA-256 nonce search: transaction types, round
// constants, IV and SHA-256 helper functions. No dependencies.
`default_nettype none
package sha_nonce_pkg;

  typedef struct packed {
    logic [63:0] midstate_w01;
    logic [63:0] midstate_w23;
    logic [63:0] midstate_w45;
    logic [63:0] midstate_w67;
    logic [63:0] tail_w01;
    logic [31:0] tail_w2;
    logic [63:0] target_q0;
    logic [63:0] target_q1;
    logic [63:0] target_q2;
    logic [63:0] target_q3;
    logic [31:0] start_nonce;
    logic [32:0] nonce_count;
  } job_t;

  typedef struct packed {
    logic        found;
    logic [31:0] winning_nonce;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // latch job
    logic blk_init;   // set up first compression of current nonce
    logic blk2_init;  // set up second compression from first digest
    logic round;      // run one round
    logic fold;       // add working vars into state
    logic next_nonce; // advance nonce
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_round;
    logic below;
    logic count_done;
  } dp_stat_t;

  localparam logic [31:0] PAD_WORD = 32'h80000000;
  localparam logic [31:0] LEN1     = 32'd640;
  localparam logic [31:0] LEN2     = 32'd256;
  localparam logic [32:0] FULL_RANGE = 33'h100000000;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] KROUND [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] swap32(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/sha256d_nonce_search.sv
// Double SHA-256 nonce search: per nonce tried, two 64-round compressions
// at one round per cycle, plus check, two folds, reseed and compare.
// Result strobe follows the compare of the first qualifying nonce, or the check
// that finds the count spent when none does; one job at a time, busy low
// again in the strobe cycle. The receiver cannot stall.
// Synchronous reset returns the controller to idle; no job is kept.
`default_nettype none
module sha256d_nonce_search
  import sha_nonce_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire job_t job,
  output logic      busy,
  output logic      done,
  output result_t   result
);

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [31:0] nonce;

  sha_nonce_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start && !busy), .stat(stat), .nonce(nonce),
    .busy(busy), .cmd(cmd), .done(done), .res(result)
  );

  sha_nonce_dp u_dp (
    .clk(clk), .job(job), .cmd(cmd), .stat(stat), .nonce(nonce)
  );

endmodule
`default_nettype wire

// File: rtl/core/sha_nonce_dp.sv
// Datapath: one SHA-256 round per cycle with a 16-word message schedule,
// nonce counter and target compare. Uses sha_nonce_pkg.
`default_nettype none
module sha_nonce_dp
  import sha_nonce_pkg::*;
(
  input  wire logic     clk,
  input  wire job_t     job,
  input  wire dp_cmd_t  cmd,
  output dp_stat_t      stat,
  output logic [31:0]   nonce
);

  job_t        jr;
  logic [31:0] st [8];
  logic [31:0] v [8];
  logic [31:0] w [16];
  logic [5:0]  rnd;
  logic [32:0] remain;
  logic [31:0] t1, t2, wn, s0, s1;
  logic [255:0] dig, tgt;

  always_comb begin
    s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    wn = w[0] + s0 + w[9] + s1;
    t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
       + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KROUND[rnd] + w[0];
    t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
       + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    for (int i = 0; i < 8; i++) begin
      dig[32*i +: 32] = swap32(st[i]);
    end
    tgt = {jr.target_q3, jr.target_q2, jr.target_q1, jr.target_q0};
  end

  assign stat.last_round = (rnd == 6'd63);
  assign stat.below      = (dig < tgt);
  assign stat.count_done = (remain == 33'd0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      jr     <= job;
      nonce  <= job.start_nonce;
      remain <= (job.nonce_count > FULL_RANGE) ? FULL_RANGE : job.nonce_count;
    end
    if (cmd.next_nonce) begin
      nonce  <= nonce + 32'd1;
      remain <= remain - 33'd1;
    end
    if (cmd.blk_init) begin
      st[0] <= jr.midstate_w01[63:32]; st[1] <= jr.midstate_w01[31:0];
      st[2] <= jr.midstate_w23[63:32]; st[3] <= jr.midstate_w23[31:0];
      st[4] <= jr.midstate_w45[63:32]; st[5] <= jr.midstate_w45[31:0];
      st[6] <= jr.midstate_w67[63:32]; st[7] <= jr.midstate_w67[31:0];
      v[0] <= jr.midstate_w01[63:32]; v[1] <= jr.midstate_w01[31:0];
      v[2] <= jr.midstate_w23[63:32]; v[3] <= jr.midstate_w23[31:0];
      v[4] <= jr.midstate_w45[63:32]; v[5] <= jr.midstate_w45[31:0];
      v[6] <= jr.midstate_w67[63:32]; v[7] <= jr.midstate_w67[31:0];
      for (int i = 0; i < 16; i++) w[i] <= '0;
      w[0]  <= jr.tail_w01[63:32];
      w[1]  <= jr.tail_w01[31:0];
      w[2]  <= jr.tail_w2;
      w[3]  <= swap32(nonce);
      w[4]  <= PAD_WORD;
      w[15] <= LEN1;
      rnd   <= '0;
    end else if (cmd.blk2_init) begin
      for (int i = 0; i < 8; i++) begin
        st[i] <= IV[i];
        v[i]  <= IV[i];
        w[i]  <= st[i];
        w[i+8] <= '0;
      end
      w[8]  <= PAD_WORD;
      w[15] <= LEN2;
      rnd   <= '0;
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wn;
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0];
      v[0] <= t1 + t2;
      rnd  <= rnd + 6'd1;
    end else if (cmd.fold) begin
      for (int i = 0; i < 8; i++) st[i] <= st[i] + v[i];
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/sha_nonce_ctrl.sv
// Controller: sequences load, two compressions per nonce, compare, result.
// Uses sha_nonce_pkg.
`default_nettype none
module sha_nonce_ctrl
  import sha_nonce_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire dp_stat_t stat,
  input  wire logic [31:0] nonce,
  output logic          busy,
  output dp_cmd_t       cmd,
  output logic          done,
  output result_t       res
);

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_R1, S_F1, S_I2, S_R2, S_F2, S_CMP
  } state_t;

  state_t state;

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE:  cmd.load = start;
      S_CHECK: cmd.blk_init = !stat.count_done;
      S_R1:    cmd.round = 1'b1;
      S_F1:    cmd.fold = 1'b1;
      S_I2:    cmd.blk2_init = 1'b1;
      S_R2:    cmd.round = 1'b1;
      S_F2:    cmd.fold = 1'b1;
      S_CMP:   cmd.next_nonce = !stat.below;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
      res   <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: if (start) begin
          state <= S_CHECK;
          busy  <= 1'b1;
        end
        S_CHECK: if (stat.count_done) begin
          state <= S_IDLE;
          busy  <= 1'b0;
          done  <= 1'b1;
          res   <= '0;
        end else begin
          state <= S_R1;
        end
        S_R1: if (stat.last_round) state <= S_F1;
        S_F1: state <= S_I2;
        S_I2: state <= S_R2;
        S_R2: if (stat.last_round) state <= S_F2;
        S_F2: state <= S_CMP;
        S_CMP: if (stat.below) begin
          state <= S_IDLE;
          busy  <= 1'b0;
          done  <= 1'b1;
          res   <= '{found: 1'b1, winning_nonce: nonce};
        end else begin
          state <= S_CHECK;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/sha_nonce_chk.sv
// Port-level checker for sha256d_nonce_search, bound to the top level.
// Uses sha_nonce_pkg.
`default_nettype none
module sha_nonce_chk
  import sha_nonce_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    start,
  input wire logic    busy,
  input wire logic    done,
  input wire result_t result
);

  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while busy");
  a_start_sets_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted job without busy");
  a_busy_falls_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done) else $error("busy dropped without result");
  a_nonce_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.found |-> result.winning_nonce == 32'd0)
    else $error("nonzero nonce when not found");

endmodule

bind sha256d_nonce_search sha_nonce_chk u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .result(result)
);
`default_nettype wire

// File: tb/tb_top.sv
// Testbench for sha256d_nonce_search: sends mining jobs, predicts each result
// with a behavioral double SHA-256 search and compares it. Uses sha_nonce_pkg.
module tb_top
  import sha_nonce_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst;
  logic start;
  job_t job;
  logic busy;
  logic done;
  result_t result;

  result_t expected_q[$];
  int mismatches;

  sha256d_nonce_search DUT (
    .clk(clk), .rst(rst), .start(start), .job(job),
    .busy(busy), .done(done), .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [31:0] H0 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bswap(logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  task automatic sha_block(inout logic [31:0] h[8], input logic [31:0] m[16]);
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++) w[i] = m[i];
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + w[i-7]
           + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
           + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
    for (int i = 0; i < 8; i++) v[i] = h[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[i] + w[i];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) h[i] += v[i];
  endtask

  // little-endian 256-bit value of the double hash for one nonce
  task automatic pow_value(input job_t j, input logic [31:0] nonce,
                           output logic [255:0] val);
    logic [31:0] st[8];
    logic [31:0] fin[8];
    logic [31:0] m[16];
    st = '{j.midstate_w01[63:32], j.midstate_w01[31:0], j.midstate_w23[63:32],
           j.midstate_w23[31:0], j.midstate_w45[63:32], j.midstate_w45[31:0],
           j.midstate_w67[63:32], j.midstate_w67[31:0]};
    foreach (m[i]) m[i] = '0;
    m[0] = j.tail_w01[63:32]; m[1] = j.tail_w01[31:0]; m[2] = j.tail_w2;
    m[3] = bswap(nonce); m[4] = 32'h80000000; m[15] = 32'd640;
    sha_block(st, m);
    foreach (m[i]) m[i] = '0;
    for (int i = 0; i < 8; i++) begin
      m[i] = st[i];
      fin[i] = H0[i];
    end
    m[8] = 32'h80000000; m[15] = 32'd256;
    sha_block(fin, m);
    for (int i = 0; i < 8; i++) val[32*i +: 32] = bswap(fin[i]);
  endtask

  task automatic predict_search(input job_t j, output result_t r);
    logic [255:0] tgt, val;
    longint unsigned cnt;
    tgt = {j.target_q3, j.target_q2, j.target_q1, j.target_q0};
    cnt = 64'(j.nonce_count);
    if (cnt > 64'h100000000) cnt = 64'h100000000;
    r = '0;
    for (longint unsigned k = 0; k < cnt; k++) begin
      pow_value(j, j.start_nonce + 32'(k), val);
      if (val < tgt) begin
        r.found = 1'b1;
        r.winning_nonce = j.start_nonce + 32'(k);
        break;
      end
    end
  endtask

  task automatic send_job(input job_t j);
    result_t r;
    predict_search(j, r);
    @(negedge clk);
    while ($urandom_range(0, 3) == 0) @(negedge clk);
    job <= j;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(r);
    @(negedge clk);
    start <= 1'b0;
    job <= '0;
    // one job at a time: wait for its result
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  function automatic job_t rand_job(int max_count);
    job_t j;
    logic [703:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom};
    j = bits[672:0];
    j.nonce_count = 33'($urandom_range(0, max_count));
    return j;
  endfunction

  // target thresholds giving a mix of hits and misses
  function automatic void set_target(inout job_t j, input int level);
    logic [255:0] t;
    t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    t = t >> level;
    {j.target_q3, j.target_q2, j.target_q1, j.target_q0} = t;
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", result);
      end else begin
        result_t e;
        e = expected_q.pop_front();
        if (result.found !== e.found || result.winning_nonce !== e.winning_nonce) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected found=%0b nonce=%h, got found=%0b nonce=%h",
                     e.found, e.winning_nonce, result.found, result.winning_nonce);
        end
      end
    end
  end

  task automatic test_extremes();
    job_t j;
    j = '0;
    send_job(j);                       // zero count
    j = '1;
    j.nonce_count = 33'd2;             // all ones, target max, wraps nonce
    send_job(j);
    j = '0;
    j.nonce_count = 33'd3;             // target zero: never below
    send_job(j);
    j = rand_job(0);
    j.nonce_count = 33'h1ffffffff;     // saturated count, first nonce hits
    {j.target_q3, j.target_q2, j.target_q1, j.target_q0} = '1;
    send_job(j);
    j = rand_job(0);
    j.nonce_count = 33'h100000000;
    j.target_q3 = '1;
    send_job(j);
    for (int b = 0; b < 8; b++) begin
      j = rand_job(4);
      set_target(j, b);
      send_job(j);
    end
  endtask

  task automatic test_equal_target();
    job_t j;
    logic [255:0] val;
    j = rand_job(0);
    j.nonce_count = 33'd1;
    pow_value(j, j.start_nonce, val);
    {j.target_q3, j.target_q2, j.target_q1, j.target_q0} = val;
    send_job(j);                       // equal: strict compare, not found
    {j.target_q3, j.target_q2, j.target_q1, j.target_q0} = val + 256'd1;
    send_job(j);
  endtask

  task automatic test_random_jobs();
    job_t j;
    for (int n = 0; n < 1530; n++) begin
      j = rand_job(n % 50 == 0 ? 12 : 3);
      set_target(j, $urandom_range(0, 4));
      send_job(j);
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    job = '0;
    mismatches = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_extremes();
    test_equal_target();
    test_random_jobs();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule
